// File: rtl/pcfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcfl_pkg;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] RSP_OK  = 2'd0;
    localparam logic [1:0] RSP_OOM = 2'd1;
    localparam logic [1:0] RSP_BAD = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [2:0]  cpu;
        logic [31:0] addr;
    } req_t;

    typedef struct packed {
        logic [31:0] page_addr;
        logic [1:0]  status;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_POP
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch the accepted request
        logic do_free;   // check address, push if good, post result
        logic rd_issue;  // pick a list and read the link of its head
        logic do_pop;    // unlink the head and post its address
        logic do_oom;    // post out of memory
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_free;
        logic found;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

// File: rtl/per_cpu_page_free_list_allocator_top.sv
// A free or out-of-memory result is registered from the decide step; a successful
// allocation from the pop step, after the registered link memory read.
// A new request is taken only in the idle state, once the decide step and, for an allocation,
// the pop step of the last item are done; both are stretched while the last result waits on rsp_ready.
// Reset (rst_n, async, active low): all lists empty, both limits 0, no result pending.
// The link memory is not cleared; a link is always written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module per_cpu_page_free_list_allocator_top #(
    parameter int CPU_COUNT  = 8,
    parameter int PAGE_COUNT = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // request channel
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire pcfl_pkg::req_t                 req,
    // result channel
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output pcfl_pkg::rsp_t                      rsp,
    // register writes
    input  wire logic                           cfg_we,
    input  wire logic [pcfl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    import pcfl_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequence each item: latch, decide, and for a successful allocation wait on the link read.
    pcfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Hold the limits, list heads, link memory and the result register.
    // The result register lets a new item in while the last result still waits.
    pcfl_dp #(
        .CPU_COUNT  (CPU_COUNT),
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // A result is only posted into a free result slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_free || cmd.do_pop || cmd.do_oom) |-> !sts.out_busy)
        else $error("result posted over a pending result");

    // A link read is always followed by a busy cycle, never a new accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |=> !req_ready)
        else $error("request accepted while a pop is in flight");

    // Out of memory only when every list is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_oom |-> !sts.found)
        else $error("out of memory reported with a listed page");

    // Accepting an item leaves the idle state, so no request is accepted in the cycle after.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !req_ready)
        else $error("request accepted back to back");

endmodule

`default_nettype wire

// File: rtl/pcfl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pcfl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/pcfl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pcfl_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire pcfl_pkg::sts_t sts,
    output pcfl_pkg::cmd_t      cmd
);

    import pcfl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (sts.is_free)
                begin
                    if (!sts.out_busy)
                    begin
                        cmd.do_free = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                else if (sts.found)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_POP;
                end
                else
                begin
                    if (!sts.out_busy)
                    begin
                        cmd.do_oom = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_POP:
            begin
                // hold until the result slot frees up
                if (!sts.out_busy)
                begin
                    cmd.do_pop = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/pcfl_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pcfl_dp #(
    parameter int CPU_COUNT  = 8,
    parameter int PAGE_COUNT = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire pcfl_pkg::req_t                     req,
    output pcfl_pkg::rsp_t                          rsp,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_ready,
    input  wire logic                               cfg_we,
    input  wire logic [pcfl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                        cfg_data,
    input  wire pcfl_pkg::cmd_t                     cmd,
    output pcfl_pkg::sts_t                          sts
);

    import pcfl_pkg::*;

    localparam int CW  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int PW  = $clog2(PAGE_COUNT);
    localparam int OB  = $clog2(PAGE_BYTES);
    localparam int APW = 32 - OB;            // page number of an address
    localparam int BPW = APW + 1;            // base page, may round up to 2^APW
    localparam int DW  = ((BPW > PW) ? BPW : PW) + 1;
    localparam int LW  = PW + 1;             // link: has-next bit and index

    function automatic logic [2:0] cpu_mod(input logic [2:0] v);
        logic [2:0] r;
        r = v;
        for (int k = 0; k < 8; k++)
        begin
            if (int'(r) >= CPU_COUNT)
            begin
                r = r - 3'(CPU_COUNT);
            end
        end
        return r;
    endfunction

    // Configuration
    logic [31:0]    low_reg;
    logic [31:0]    high_reg;
    logic [BPW-1:0] base_page_reg;
    logic [BPW-1:0] base_page_next;

    assign base_page_next = {1'b0, cfg_data[31:OB]} + BPW'(|cfg_data[OB-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= '0;
            high_reg      <= '0;
            base_page_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOW_LIMIT:
                begin
                    low_reg       <= cfg_data;
                    base_page_reg <= base_page_next;
                end
                CFG_HIGH_LIMIT:
                begin
                    high_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Request latch
    req_t          req_reg;
    logic [CW-1:0] cpu_reg;
    logic [CW-1:0] sel_reg;

    // List heads
    logic [PW-1:0]        head_reg [CPU_COUNT];
    logic [CPU_COUNT-1:0] ne_reg;

    logic [CW-1:0] first;
    logic [CW-1:0] pick;
    logic [CW-1:0] rd_sel;
    logic [PW-1:0] head_rd;

    always_comb
    begin
        first = '0;
        for (int i = CPU_COUNT - 1; i >= 0; i--)
        begin
            if (ne_reg[i])
            begin
                first = CW'(i);
            end
        end
    end

    assign pick    = ne_reg[cpu_reg] ? cpu_reg : first;
    assign rd_sel  = cmd.do_pop ? sel_reg : pick;
    assign head_rd = head_reg[rd_sel];

    // Free address check
    logic          aligned;
    logic          ge_low;
    logic          lt_high;
    logic [DW-1:0] addr_pg;
    logic [DW-1:0] base_pg;
    logic [DW-1:0] diff;
    logic          ge_base;
    logic          in_cap;
    logic          free_ok;
    logic [PW-1:0] free_idx;

    assign aligned  = (req_reg.addr[OB-1:0] == '0);
    assign ge_low   = (req_reg.addr >= low_reg);
    assign lt_high  = (req_reg.addr < high_reg);
    assign addr_pg  = DW'(req_reg.addr[31:OB]);
    assign base_pg  = DW'(base_page_reg);
    assign ge_base  = (addr_pg >= base_pg);
    assign diff     = addr_pg - base_pg;
    assign in_cap   = (diff < DW'(PAGE_COUNT));
    assign free_ok  = aligned && ge_low && lt_high && ge_base && in_cap;
    assign free_idx = diff[PW-1:0];

    // Link memory
    logic          ram_we;
    logic [LW-1:0] ram_wdata;
    logic [LW-1:0] ram_rdata;

    assign ram_we    = cmd.do_free && free_ok;
    assign ram_wdata = ne_reg[cpu_reg] ? {1'b1, head_rd} : '0;

    pcfl_ram #(
        .WIDTH (LW),
        .DEPTH (PAGE_COUNT)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx),
        .wdata (ram_wdata),
        .re    (cmd.rd_issue),
        .raddr (head_rd),
        .rdata (ram_rdata)
    );

    // Address of the popped page
    logic [DW-1:0] pop_sum;
    logic [31:0]   pop_addr;

    assign pop_sum  = base_pg + DW'(head_rd);
    assign pop_addr = {pop_sum[APW-1:0], {OB{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
            cpu_reg <= CW'(cpu_mod(req.cpu));
        end
        if (cmd.rd_issue)
        begin
            sel_reg <= pick;
        end
        if (ram_we)
        begin
            head_reg[cpu_reg] <= free_idx;
        end
        else if (cmd.do_pop)
        begin
            head_reg[sel_reg] <= ram_rdata[LW-1] ? ram_rdata[PW-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ne_reg <= '0;
        end
        else if (ram_we)
        begin
            ne_reg[cpu_reg] <= 1'b1;
        end
        else if (cmd.do_pop)
        begin
            ne_reg[sel_reg] <= ram_rdata[LW-1];
        end
    end

    // Result register
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic post;

    assign post = cmd.do_free || cmd.do_pop || cmd.do_oom;

    always_comb
    begin
        rsp_next = rsp_reg;
        priority if (cmd.do_free)
        begin
            rsp_next.page_addr = '0;
            rsp_next.status    = free_ok ? RSP_OK : RSP_BAD;
        end
        else if (cmd.do_pop)
        begin
            rsp_next.page_addr = pop_addr;
            rsp_next.status    = RSP_OK;
        end
        else if (cmd.do_oom)
        begin
            rsp_next.page_addr = '0;
            rsp_next.status    = RSP_OOM;
        end
        else
        begin
            rsp_next = rsp_reg;
        end
        rsp_valid_next = post ? 1'b1 : (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    assign sts.is_free  = (req_reg.kind == KIND_FREE);
    assign sts.found    = |ne_reg;
    assign sts.out_busy = rsp_valid_reg && !rsp_ready;

endmodule

`default_nettype wire
